// ===== design/emt_pkg.sv =====
// ---------------------------------------------------------------------------
// emt_pkg
// shared types, codes and helpers of the expiring mark table
// ---------------------------------------------------------------------------
`default_nettype none

package emt_pkg;

    localparam int TIME_W    = 32;
    localparam int IN_KEY_W  = 32;
    localparam int WINDOW_W  = 16;
    localparam int LIMIT_W   = 2;
    localparam int AGE_W     = 16;
    localparam int CNT_W     = 32;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 16;

    // request modes
    localparam logic [MODE_W-1:0] MODE_MARK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LATE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_LIMIT = 4'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd750;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 2'd3;

    // scan summary handed from cell to cell
    typedef struct packed {
        logic               live_hit;
        logic               match_found;
        logic               match_live;
        logic [LIMIT_W-1:0] match_logs;
        logic [TIME_W-1:0]  match_age;
        logic               free_found;
        logic [TIME_W-1:0]  oldest_age;
    } t_scan;

    // write-back broadcast to the cells
    typedef struct packed {
        logic clear;
        logic mark;
        logic bump;
    } t_wr_cmd;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== design/emt_in_if.sv =====
// ---------------------------------------------------------------------------
// emt_in_if
// request channel of the expiring mark table
// ---------------------------------------------------------------------------
`default_nettype none

interface emt_in_if;
    import emt_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [IN_KEY_W-1:0] object_key;
    logic [TIME_W-1:0]   now_ms;
    logic                qualifies;
    logic                object_alive;
    logic                session_connected;

    modport source (output valid, mode, object_key, now_ms, qualifies, object_alive,
                    session_connected, input ready);
    modport sink   (input valid, mode, object_key, now_ms, qualifies, object_alive,
                    session_connected, output ready);
endinterface

`default_nettype wire

// ===== design/emt_out_if.sv =====
// ---------------------------------------------------------------------------
// emt_out_if
// result channel of the expiring mark table
// ---------------------------------------------------------------------------
`default_nettype none

interface emt_out_if;
    import emt_pkg::*;

    logic             valid;
    logic             ready;
    logic             added;
    logic             refused;
    logic             evicted;
    logic             log_permit;
    logic [AGE_W-1:0] age_ms;
    logic [CNT_W-1:0] seen_count;
    logic [CNT_W-1:0] refused_count;
    logic [CNT_W-1:0] marked_count;
    logic [CNT_W-1:0] late_count;
    logic [CNT_W-1:0] evicted_count;

    modport source (output valid, added, refused, evicted, log_permit, age_ms, seen_count,
                    refused_count, marked_count, late_count, evicted_count, input ready);
    modport sink   (input valid, added, refused, evicted, log_permit, age_ms, seen_count,
                    refused_count, marked_count, late_count, evicted_count, output ready);
endinterface

`default_nettype wire

// ===== design/emt_cfg_if.sv =====
// ---------------------------------------------------------------------------
// emt_cfg_if
// register write channel of the expiring mark table
// ---------------------------------------------------------------------------
`default_nettype none

interface emt_cfg_if;
    import emt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/emt_cell.sv =====
// ---------------------------------------------------------------------------
// emt_cell
// one table entry plus the scan stage that visits it
// ---------------------------------------------------------------------------
`default_nettype none

module emt_cell #(
    parameter int KEY_BITS = 32,
    parameter int IDX_W    = 5,
    parameter int IDX      = 0
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [KEY_BITS-1:0]     i_key,
    input  wire logic [emt_pkg::TIME_W-1:0]   i_now,
    input  wire logic [emt_pkg::WINDOW_W-1:0] i_window,
    input  wire logic                    i_load,
    input  wire emt_pkg::t_scan          i_scan,
    input  wire logic [IDX_W-1:0]        i_match_idx,
    input  wire logic [IDX_W-1:0]        i_free_idx,
    input  wire logic [IDX_W-1:0]        i_oldest_idx,
    input  wire emt_pkg::t_wr_cmd        i_wr,
    input  wire logic [IDX_W-1:0]        i_wr_idx,
    output logic                         o_valid,
    output emt_pkg::t_scan               o_scan,
    output logic [IDX_W-1:0]             o_match_idx,
    output logic [IDX_W-1:0]             o_free_idx,
    output logic [IDX_W-1:0]             o_oldest_idx
);
    import emt_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [KEY_BITS-1:0] r_ent_key;
    logic [TIME_W-1:0]   r_ent_birth;
    logic [LIMIT_W-1:0]  r_ent_logs;

    logic                r_valid;
    t_scan               r_scan;
    logic [IDX_W-1:0]    r_match_idx;
    logic [IDX_W-1:0]    r_free_idx;
    logic [IDX_W-1:0]    r_oldest_idx;

    logic [TIME_W-1:0]   w_age;
    logic                w_expired;
    logic                w_hit;
    logic                w_sel;

    assign w_age     = i_now - r_ent_birth;
    assign w_expired = w_age >= TIME_W'(i_window);
    assign w_hit     = r_ent_key == i_key;
    assign w_sel     = i_wr_idx == MY_IDX;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clear) begin
            r_ent_key   <= '0;
            r_ent_birth <= '0;
            r_ent_logs  <= '0;
        end else if (i_wr.mark && w_sel) begin
            r_ent_key   <= i_key;
            r_ent_birth <= i_now;
            r_ent_logs  <= '0;
        end else if (i_wr.bump && w_sel) begin
            r_ent_logs  <= r_ent_logs + LIMIT_W'(1);
        end
    end

    // scan stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load;
        end
        r_scan       <= i_scan;
        r_match_idx  <= i_match_idx;
        r_free_idx   <= i_free_idx;
        r_oldest_idx <= i_oldest_idx;
    end

    always_comb begin
        o_scan       = r_scan;
        o_match_idx  = r_match_idx;
        o_free_idx   = r_free_idx;
        o_oldest_idx = r_oldest_idx;
        if (w_hit && !w_expired) begin
            o_scan.live_hit = 1'b1;
        end
        if (!r_scan.free_found && ((r_ent_key == '0) || w_expired)) begin
            o_scan.free_found = 1'b1;
            o_free_idx        = MY_IDX;
        end
        if (!r_scan.free_found && (w_age > r_scan.oldest_age)) begin
            o_scan.oldest_age = w_age;
            o_oldest_idx      = MY_IDX;
        end
        if (!r_scan.match_found && w_hit) begin
            o_scan.match_found = 1'b1;
            o_scan.match_live  = !w_expired;
            o_scan.match_logs  = r_ent_logs;
            o_scan.match_age   = w_age;
            o_match_idx        = MY_IDX;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== design/expiring_mark_table.sv =====
// ---------------------------------------------------------------------------
// expiring_mark_table
// keyed marks with a birth time that lapse after a window, held in a row
// of cells that a scan word walks through one cell per clock
// ---------------------------------------------------------------------------
// The table is a row of ENTRIES cells. Each cell holds one entry (key,
// birth time, refusal log count) and a stage of the scan pipe. A mark or a
// query that needs the table enters cell 0 at acceptance and moves one
// cell per clock, each cell folding its entry into the summary (live hit,
// first free or lapsed entry, oldest live entry, first key match). After
// the last cell a finish cycle decides the outcome, writes back to the
// chosen cell by broadcast and loads the result register. The result word
// of a scanned item is presented after the walk along the cell row and
// the finish cycle, and the next word can be taken once the finish cycle
// has passed; an item that needs no scan (zero key, non-qualifying mark,
// query with no session, clear) goes straight to the finish cycle. One
// item is in flight at a time; the next is taken while the previous
// result still waits in the output register, but its finish cycle holds
// until that register is free. Reset and clear empty every entry at once,
// so no clearing pass is needed. Configuration writes are always ready
// and must only be issued while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module expiring_mark_table #(
    parameter int ENTRIES  = 32,
    parameter int KEY_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    emt_in_if.sink     i_in,
    emt_out_if.source  o_out,
    emt_cfg_if.sink    i_cfg
);
    import emt_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state               r_state;

    // configuration
    logic [WINDOW_W-1:0]  r_window;
    logic [LIMIT_W-1:0]   r_log_limit;

    // the word being worked on
    logic [MODE_W-1:0]    r_mode;
    logic [KEY_BITS-1:0]  r_key;
    logic [TIME_W-1:0]    r_now;
    logic                 r_alive;
    logic                 r_scan_req;

    // scan summary from the end of the row
    t_scan                r_fin;
    logic [IDX_W-1:0]     r_fin_match_idx;
    logic [IDX_W-1:0]     r_fin_free_idx;
    logic [IDX_W-1:0]     r_fin_oldest_idx;

    // totals
    logic [CNT_W-1:0]     r_seen;
    logic [CNT_W-1:0]     r_refused_tot;
    logic [CNT_W-1:0]     r_marked;
    logic [CNT_W-1:0]     r_late;
    logic [CNT_W-1:0]     r_evicted_tot;
    logic [CNT_W-1:0]     n_seen;
    logic [CNT_W-1:0]     n_refused_tot;
    logic [CNT_W-1:0]     n_marked;
    logic [CNT_W-1:0]     n_late;
    logic [CNT_W-1:0]     n_evicted_tot;

    // result register
    logic                 r_out_valid;
    logic                 r_added;
    logic                 r_refused;
    logic                 r_evicted;
    logic                 r_permit;
    logic [AGE_W-1:0]     r_age;

    logic [KEY_BITS-1:0]  w_in_key;
    logic                 w_accept;
    logic                 w_scan_need;
    logic                 w_out_free;
    logic                 w_finish;

    logic                 w_is_mark;
    logic                 w_is_query;
    logic                 w_is_clear;
    logic                 w_key_nz;
    logic                 w_add;
    logic                 w_evict;
    logic                 w_refuse;
    logic                 w_permit;
    logic [AGE_W-1:0]     w_age_sat;
    logic [IDX_W-1:0]     w_slot;

    t_wr_cmd              w_wr;
    logic [IDX_W-1:0]     w_wr_idx;

    // cell row wiring
    logic                 w_cv   [ENTRIES];
    t_scan                w_cs   [ENTRIES];
    logic [IDX_W-1:0]     w_cmi  [ENTRIES];
    logic [IDX_W-1:0]     w_cfi  [ENTRIES];
    logic [IDX_W-1:0]     w_coi  [ENTRIES];

    // key as stored, low KEY_BITS bits of the input key, zero-extended if KEY_BITS is wider
    generate
        if (KEY_BITS > IN_KEY_W) begin : g_key_wide
            assign w_in_key = {{(KEY_BITS-IN_KEY_W){1'b0}}, i_in.object_key};
        end else if (KEY_BITS == IN_KEY_W) begin : g_key_same
            assign w_in_key = i_in.object_key;
        end else begin : g_key_narrow
            assign w_in_key = i_in.object_key[KEY_BITS-1:0];
        end
    endgenerate

    assign i_in.ready  = r_state == S_IDLE;
    assign w_accept    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // a scan is needed for a qualifying mark or a connected query with a nonzero key
    assign w_scan_need = (w_in_key != '0)
                       && ((((i_in.mode == MODE_MARK) || (i_in.mode == MODE_LATE))
                            && i_in.qualifies)
                           || ((i_in.mode == MODE_QUERY) && i_in.session_connected));

    // the row of cells
    generate
        for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
            logic             w_load;
            t_scan            w_scan_in;
            logic [IDX_W-1:0] w_mi_in;
            logic [IDX_W-1:0] w_fi_in;
            logic [IDX_W-1:0] w_oi_in;

            if (g == 0) begin : g_head
                // fresh summary: nothing found, oldest starts at entry 0
                assign w_load    = w_accept && w_scan_need;
                assign w_scan_in = '0;
                assign w_mi_in   = '0;
                assign w_fi_in   = '0;
                assign w_oi_in   = '0;
            end else begin : g_link
                assign w_load    = w_cv[g-1];
                assign w_scan_in = w_cs[g-1];
                assign w_mi_in   = w_cmi[g-1];
                assign w_fi_in   = w_cfi[g-1];
                assign w_oi_in   = w_coi[g-1];
            end

            emt_cell #(
                .KEY_BITS (KEY_BITS),
                .IDX_W    (IDX_W),
                .IDX      (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_key        (r_key),
                .i_now        (r_now),
                .i_window     (r_window),
                .i_load       (w_load),
                .i_scan       (w_scan_in),
                .i_match_idx  (w_mi_in),
                .i_free_idx   (w_fi_in),
                .i_oldest_idx (w_oi_in),
                .i_wr         (w_wr),
                .i_wr_idx     (w_wr_idx),
                .o_valid      (w_cv[g]),
                .o_scan       (w_cs[g]),
                .o_match_idx  (w_cmi[g]),
                .o_free_idx   (w_cfi[g]),
                .o_oldest_idx (w_coi[g])
            );
        end
    endgenerate

    // finish decision
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_finish   = (r_state == S_FIN) && w_out_free;

    assign w_is_mark  = (r_mode == MODE_MARK) || (r_mode == MODE_LATE);
    assign w_is_query = r_mode == MODE_QUERY;
    assign w_is_clear = r_mode == MODE_CLEAR;
    assign w_key_nz   = r_key != '0;

    // mark: reuse first free or lapsed entry, else evict the oldest
    assign w_add      = w_is_mark && r_scan_req && !r_fin.live_hit;
    assign w_evict    = w_add && !r_fin.free_found;
    assign w_slot     = r_fin.free_found ? r_fin_free_idx : r_fin_oldest_idx;

    // query: only the first matching entry counts
    assign w_refuse   = w_is_query && r_scan_req && r_fin.match_found
                      && r_fin.match_live && r_alive;
    assign w_permit   = w_refuse && (r_fin.match_logs < r_log_limit);
    assign w_age_sat  = (|r_fin.match_age[TIME_W-1:AGE_W]) ? '1
                                                           : r_fin.match_age[AGE_W-1:0];

    assign w_wr.clear = w_finish && w_is_clear;
    assign w_wr.mark  = w_finish && w_add;
    assign w_wr.bump  = w_finish && w_permit;
    assign w_wr_idx   = w_permit ? r_fin_match_idx : w_slot;

    always_comb begin
        n_seen        = r_seen;
        n_refused_tot = r_refused_tot;
        n_marked      = r_marked;
        n_late        = r_late;
        n_evicted_tot = r_evicted_tot;
        if (w_is_clear) begin
            n_seen        = '0;
            n_refused_tot = '0;
            n_marked      = '0;
            n_late        = '0;
            n_evicted_tot = '0;
        end else begin
            if (w_is_query && w_key_nz) begin
                n_seen = sat_inc(r_seen);
            end
            if (w_refuse) begin
                n_refused_tot = sat_inc(r_refused_tot);
            end
            if (w_add) begin
                n_marked = sat_inc(r_marked);
            end
            if (w_add && (r_mode == MODE_LATE)) begin
                n_late = sat_inc(r_late);
            end
            if (w_evict) begin
                n_evicted_tot = sat_inc(r_evicted_tot);
            end
        end
    end

    // sequencer, registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window      <= WINDOW_RST;
            r_log_limit   <= LIMIT_RST;
            r_out_valid   <= 1'b0;
            r_seen        <= '0;
            r_refused_tot <= '0;
            r_marked      <= '0;
            r_late        <= '0;
            r_evicted_tot <= '0;
            r_scan_req    <= 1'b0;
        end else begin
            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_WINDOW) begin
                    r_window <= i_cfg.data[WINDOW_W-1:0];
                end else if (i_cfg.index == REG_LOG_LIMIT) begin
                    r_log_limit <= i_cfg.data[LIMIT_W-1:0];
                end
            end

            // result word: loaded at finish, emptied once taken
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_scan_req <= w_scan_need;
                        r_state    <= w_scan_need ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    // summary leaves the last cell
                    if (w_cv[ENTRIES-1]) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_seen        <= n_seen;
                        r_refused_tot <= n_refused_tot;
                        r_marked      <= n_marked;
                        r_late        <= n_late;
                        r_evicted_tot <= n_evicted_tot;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_in.mode;
            r_key   <= w_in_key;
            r_now   <= i_in.now_ms;
            r_alive <= i_in.object_alive;
        end
        if ((r_state == S_SCAN) && w_cv[ENTRIES-1]) begin
            r_fin            <= w_cs[ENTRIES-1];
            r_fin_match_idx  <= w_cmi[ENTRIES-1];
            r_fin_free_idx   <= w_cfi[ENTRIES-1];
            r_fin_oldest_idx <= w_coi[ENTRIES-1];
        end else if (w_accept) begin
            // nothing found unless a scan says otherwise
            r_fin <= '0;
        end
        if (w_finish) begin
            r_added   <= w_add;
            r_refused <= w_refuse;
            r_evicted <= w_evict;
            r_permit  <= w_permit;
            r_age     <= w_refuse ? w_age_sat : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.added         = r_added;
    assign o_out.refused       = r_refused;
    assign o_out.evicted       = r_evicted;
    assign o_out.log_permit    = r_permit;
    assign o_out.age_ms        = r_age;
    assign o_out.seen_count    = r_seen;
    assign o_out.refused_count = r_refused_tot;
    assign o_out.marked_count  = r_marked;
    assign o_out.late_count    = r_late;
    assign o_out.evicted_count = r_evicted_tot;

endmodule

`default_nettype wire

// ===== tb/sv/expiring_mark_table_chk.sv =====
// ---------------------------------------------------------------------------
// expiring_mark_table_chk
// watches the request, result and register channels, keeps its own model of
// the mark table and compares every result word with the predicted one
// ---------------------------------------------------------------------------

module expiring_mark_table_chk #(
    parameter int ENTRIES  = 32,
    parameter int KEY_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    emt_in_if    i_req,
    emt_out_if   i_res,
    emt_cfg_if   i_cfg,
    output int   o_checked,
    output int   o_fails
);
    timeunit 1ns;
    timeprecision 1ps;
    import emt_pkg::*;

    localparam int LOUD_LIMIT = 40;
    localparam logic [IN_KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= IN_KEY_W) ? '1 : IN_KEY_W'((64'd1 << KEY_BITS) - 64'd1);

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [IN_KEY_W-1:0] key;
        logic [TIME_W-1:0]   now;
        logic                qual;
        logic                alive;
        logic                conn;
    } t_request;

    typedef struct packed {
        logic             added;
        logic             refused;
        logic             evicted;
        logic             permit;
        logic [AGE_W-1:0] age;
        logic [CNT_W-1:0] seen;
        logic [CNT_W-1:0] refusals;
        logic [CNT_W-1:0] marks;
        logic [CNT_W-1:0] late;
        logic [CNT_W-1:0] evictions;
    } t_outcome;

    // model of the table
    logic [IN_KEY_W-1:0] mark_key   [ENTRIES];
    logic [TIME_W-1:0]   mark_birth [ENTRIES];
    logic [LIMIT_W-1:0]  mark_logs  [ENTRIES];
    logic [CNT_W-1:0]    seen_tot, refused_tot, marked_tot, late_tot, evicted_tot;
    logic [WINDOW_W-1:0] window_ms;
    logic [LIMIT_W-1:0]  log_limit;

    t_outcome pending_outcomes[$];

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void wipe_table();
        for (int i = 0; i < ENTRIES; i++) begin
            mark_key[i]   = '0;
            mark_birth[i] = '0;
            mark_logs[i]  = '0;
        end
        seen_tot    = '0;
        refused_tot = '0;
        marked_tot  = '0;
        late_tot    = '0;
        evicted_tot = '0;
    endfunction

    function automatic t_outcome apply_request(input t_request r);
        t_outcome            res;
        logic [IN_KEY_W-1:0] key;
        logic [TIME_W-1:0]   age;
        logic [TIME_W-1:0]   oldest_age;
        logic                live;
        logic                found;
        int                  slot;
        int                  oldest;
        res = '0;
        key = r.key & KEY_MASK;
        case (r.mode)
            MODE_MARK, MODE_LATE: begin
                if (key != '0 && r.qual) begin
                    live = 1'b0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        age = r.now - mark_birth[i];
                        if (mark_key[i] == key && age < window_ms) live = 1'b1;
                    end
                    if (!live) begin
                        slot   = -1;
                        oldest = 0;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (slot < 0) begin
                                age        = r.now - mark_birth[i];
                                oldest_age = r.now - mark_birth[oldest];
                                if (mark_key[i] == '0 || age >= window_ms) slot = i;
                                else if (age > oldest_age) oldest = i;
                            end
                        end
                        if (slot < 0) begin
                            slot        = oldest;
                            res.evicted = 1'b1;
                            evicted_tot = bump(evicted_tot);
                        end
                        mark_key[slot]   = key;
                        mark_birth[slot] = r.now;
                        mark_logs[slot]  = '0;
                        marked_tot       = bump(marked_tot);
                        if (r.mode == MODE_LATE) late_tot = bump(late_tot);
                        res.added = 1'b1;
                    end
                end
            end
            MODE_QUERY: begin
                if (key != '0) begin
                    seen_tot = bump(seen_tot);
                    found    = 1'b0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        // only the first holder of the key is looked at
                        if (r.conn && !found && mark_key[i] == key) begin
                            found = 1'b1;
                            age   = r.now - mark_birth[i];
                            if (age < window_ms && r.alive) begin
                                res.refused = 1'b1;
                                refused_tot = bump(refused_tot);
                                res.age     = (age > TIME_W'({AGE_W{1'b1}})) ? '1
                                                                              : age[AGE_W-1:0];
                                if (mark_logs[i] < log_limit) begin
                                    res.permit   = 1'b1;
                                    mark_logs[i] = mark_logs[i] + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            MODE_CLEAR: wipe_table();
        endcase
        res.seen      = seen_tot;
        res.refusals  = refused_tot;
        res.marks     = marked_tot;
        res.late      = late_tot;
        res.evictions = evicted_tot;
        return res;
    endfunction

    function automatic int field_check(input string name, input logic [CNT_W-1:0] want_v,
                                       input logic [CNT_W-1:0] got_v, input bit loud);
        if (got_v !== want_v) begin
            if (loud)
                $display("%0t: %s differs, expected %0h, actual %0h", $time, name, want_v,
                         got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_request req;
        t_outcome want;
        t_outcome got;
        int       bad;
        bit       loud;
        bad  = 0;
        loud = (o_fails < LOUD_LIMIT);
        if (!i_rst_n) begin
            wipe_table();
            window_ms = WINDOW_RST;
            log_limit = LIMIT_RST;
            pending_outcomes.delete();
            o_checked <= 0;
            o_fails   <= 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.added, i_res.refused, i_res.evicted, i_res.log_permit,
                        i_res.age_ms, i_res.seen_count, i_res.refused_count,
                        i_res.marked_count, i_res.late_count, i_res.evicted_count};
                if (pending_outcomes.size() == 0) begin
                    if (loud)
                        $display("%0t: result word with nothing pending, expected none, actual %0h",
                                 $time, got);
                    bad = 1;
                end else begin
                    want = pending_outcomes.pop_front();
                    bad += field_check("added", want.added, got.added, loud);
                    bad += field_check("refused", want.refused, got.refused, loud);
                    bad += field_check("evicted", want.evicted, got.evicted, loud);
                    bad += field_check("log_permit", want.permit, got.permit, loud);
                    bad += field_check("age_ms", want.age, got.age, loud);
                    bad += field_check("seen_count", want.seen, got.seen, loud);
                    bad += field_check("refused_count", want.refusals, got.refusals, loud);
                    bad += field_check("marked_count", want.marks, got.marks, loud);
                    bad += field_check("late_count", want.late, got.late, loud);
                    bad += field_check("evicted_count", want.evictions, got.evictions, loud);
                end
                o_checked <= o_checked + 1;
                if (bad != 0) o_fails <= o_fails + 1;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_WINDOW:    window_ms = i_cfg.data[WINDOW_W-1:0];
                    REG_LOG_LIMIT: log_limit = i_cfg.data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                req = '{i_req.mode, i_req.object_key, i_req.now_ms, i_req.qualifies,
                        i_req.object_alive, i_req.session_connected};
                pending_outcomes.push_back(apply_request(req));
            end
        end
    end

endmodule

// ===== tb/sv/expiring_mark_table_tb.sv =====
// ---------------------------------------------------------------------------
// expiring_mark_table_tb
// drives the mark table with a directed opening and then random marks,
// queries and clears under several register settings and idling patterns;
// the checker beside the block predicts and compares every result word
// ---------------------------------------------------------------------------

module expiring_mark_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import emt_pkg::*;

    localparam realtime HALF_PERIOD     = 1.0;
    localparam int      RESET_CYCLES    = 9;
    localparam int      ENTRIES         = 32;
    localparam int      PHASES          = 6;
    localparam int      ITEMS_PER_PHASE = 125;
    // keys drawn from a pool a little larger than the table, so that marks
    // collide with live keys and the table overflows into eviction
    localparam int      KEY_POOL        = 40;
    // limit in ns on the whole run, for the hard stop below
    localparam int      LIMIT_NS        = 1_500_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    emt_in_if  in_if ();
    emt_out_if out_if ();
    emt_cfg_if cfg_if ();

    int checked;
    int fails;
    int sent;
    int snd_idle;
    int rcv_idle;

    // current time of the stimulus and the window it believes is set
    logic [TIME_W-1:0]   clock_ms;
    logic [WINDOW_W-1:0] cur_window;

    expiring_mark_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    expiring_mark_table_chk #(
        .ENTRIES (ENTRIES)
    ) u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (in_if),
        .i_res     (out_if),
        .i_cfg     (cfg_if),
        .o_checked (checked),
        .o_fails   (fails)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle);
    end

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // one request word; valid stays high into the next word unless the
    // sender decides to idle first
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [IN_KEY_W-1:0] key,
                                input logic [TIME_W-1:0] now, input logic qual,
                                input logic alive, input logic conn);
        while ($urandom_range(99) < snd_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid             <= 1'b1;
        in_if.mode              <= mode;
        in_if.object_key        <= key;
        in_if.now_ms            <= now;
        in_if.qualifies         <= qual;
        in_if.object_alive      <= alive;
        in_if.session_connected <= conn;
        do @(posedge i_clk); while (!in_if.ready);
        sent++;
    endtask

    // mostly marks and queries on a small key pool with slowly advancing
    // time, some zero or wide keys, rare time jumps and rarer clears
    task automatic send_random_request();
        int                  roll;
        logic [MODE_W-1:0]   mode;
        logic [IN_KEY_W-1:0] key;
        roll = $urandom_range(99);
        if (roll < 46)      mode = $urandom_range(1) ? MODE_LATE : MODE_MARK;
        else if (roll < 99) mode = MODE_QUERY;
        else                mode = MODE_CLEAR;
        roll = $urandom_range(99);
        if (roll < 5)       key = '0;
        else if (roll < 15) key = $urandom();
        else                key = $urandom_range(KEY_POOL, 1);
        if ($urandom_range(99) < 2) clock_ms = $urandom();
        else                        clock_ms += $urandom_range(int'(cur_window) / 64 + 1, 0);
        send_request(mode, key, clock_ms, $urandom_range(99) < 90, $urandom_range(99) < 85,
                     $urandom_range(99) < 85);
    endtask

    // both registers plus one write to an index past the register list,
    // which the block must ignore; valid is held across the three words
    task automatic program_regs(input logic [WINDOW_W-1:0] win, input logic [LIMIT_W-1:0] lim);
        logic [CFG_DAT_W-1:0] lim_word;
        lim_word                  = $urandom();
        lim_word[LIMIT_W-1:0]     = lim;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_WINDOW;
        cfg_if.data  <= win;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.index <= REG_LOG_LIMIT;
        cfg_if.data  <= lim_word;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.index <= $urandom_range(2 ** CFG_IDX_W - 1, REG_LOG_LIMIT + 1);
        cfg_if.data  <= $urandom();
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cur_window = win;
    endtask

    task automatic wait_drained();
        while (checked != sent) @(posedge i_clk);
    endtask

    // opening sequence at the reset settings (window 750 ms, three logs)
    task automatic run_directed();
        localparam logic [IN_KEY_W-1:0] KEY_TOP = '1;
        localparam logic [TIME_W-1:0]   T_WRAP  = 32'hFFFF_FF00;
        // zero key and a non-qualifying object are both ignored
        send_request(MODE_MARK, '0, T_WRAP, 1'b1, 1'b1, 1'b1);
        send_request(MODE_MARK, KEY_TOP, T_WRAP, 1'b0, 1'b1, 1'b1);
        // fresh mark just before the time wraps, then a repeat while live
        send_request(MODE_MARK, KEY_TOP, T_WRAP, 1'b1, 1'b1, 1'b1);
        send_request(MODE_LATE, KEY_TOP, T_WRAP + 32'h10, 1'b1, 1'b1, 1'b1);
        // query across the wrap: refused with a log permit
        send_request(MODE_QUERY, KEY_TOP, 32'h0000_0050, 1'b0, 1'b1, 1'b1);
        // no session, then a dead object, then a zero key
        send_request(MODE_QUERY, KEY_TOP, 32'h0000_0050, 1'b0, 1'b1, 1'b0);
        send_request(MODE_QUERY, KEY_TOP, 32'h0000_0050, 1'b0, 1'b0, 1'b1);
        send_request(MODE_QUERY, '0, 32'h0000_0050, 1'b0, 1'b1, 1'b1);
        // use up the log permits and go one past
        repeat (3) send_request(MODE_QUERY, KEY_TOP, 32'h0000_0058, 1'b0, 1'b1, 1'b1);
        // backstop mark into the next empty entry, queried at age zero
        send_request(MODE_LATE, 32'h0000_0001, 32'h0000_0060, 1'b1, 1'b1, 1'b1);
        send_request(MODE_QUERY, 32'h0000_0001, 32'h0000_0060, 1'b0, 1'b1, 1'b1);
        // first mark has lapsed: query not refused, mark reuses its entry
        send_request(MODE_QUERY, KEY_TOP, 32'h0000_0400, 1'b0, 1'b1, 1'b1);
        send_request(MODE_LATE, KEY_TOP, 32'h0000_0400, 1'b1, 1'b1, 1'b1);
        send_request(MODE_QUERY, 32'h8000_0000, 32'h0000_0400, 1'b0, 1'b1, 1'b1);
        // window edge: one ms before expiry and exactly at it
        send_request(MODE_MARK, 32'h0000_0002, 32'h0000_0400, 1'b1, 1'b1, 1'b1);
        send_request(MODE_QUERY, 32'h0000_0002, 32'h0000_0400 + 32'd749, 1'b0, 1'b1, 1'b1);
        send_request(MODE_QUERY, 32'h0000_0002, 32'h0000_0400 + 32'd750, 1'b0, 1'b1, 1'b1);
        // clear, then a query on a key that was there before
        send_request(MODE_CLEAR, $urandom(), $urandom(), 1'b1, 1'b1, 1'b1);
        send_request(MODE_QUERY, 32'h0000_0001, 32'h0000_0800, 1'b0, 1'b1, 1'b1);
        clock_ms = 32'h0000_0900;
    endtask

    initial begin
        logic [WINDOW_W-1:0] win;
        logic [LIMIT_W-1:0]  lim;
        // every input known from time zero
        i_rst_n                  = 1'b0;
        in_if.valid              = 1'b0;
        in_if.mode               = MODE_MARK;
        in_if.object_key         = '0;
        in_if.now_ms             = '0;
        in_if.qualifies          = 1'b0;
        in_if.object_alive       = 1'b0;
        in_if.session_connected  = 1'b0;
        out_if.ready             = 1'b0;
        cfg_if.valid             = 1'b0;
        cfg_if.index             = REG_WINDOW;
        cfg_if.data              = '0;
        sent                     = 0;
        snd_idle                 = 0;
        rcv_idle                 = 0;
        clock_ms                 = '0;
        cur_window               = WINDOW_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // idling: sender light and receiver heavy, then swapped, then none
            case (ph / 2)
                0:       begin snd_idle = 35; rcv_idle <= 78; end
                1:       begin snd_idle = 78; rcv_idle <= 35; end
                default: begin snd_idle = 0;  rcv_idle <= 0;  end
            endcase
            // register settings, extremes first, a random one last
            case (ph)
                1:       begin win = '1;    lim = 2'd0; end
                2:       begin win = 16'd1; lim = 2'd3; end
                3:       begin win = '0;    lim = 2'd2; end
                4:       begin win = 16'd300; lim = 2'd1; end
                default: begin win = $urandom_range(5000, 2); lim = $urandom_range(3); end
            endcase
            if (ph == 0) begin
                run_directed();
            end else begin
                // registers change only with the table idle
                wait_drained();
                program_regs(win, lim);
            end
            repeat (ITEMS_PER_PHASE) send_random_request();
            in_if.valid <= 1'b0;
        end

        // drain, then leave room for any stray result word
        wait_drained();
        repeat (ENTRIES + 8) @(posedge i_clk);

        $display("checked %0d result words from %0d requests over %0d register settings",
                 checked, sent, PHASES);
        $display("windows from 0 to 65535 ms, log limits 0 to 3, three idling patterns");
        if (fails == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
